@@ rtl/psds_pkg.sv @@
// ----------------------------------------------------------------------------
// psds_pkg
// Types and constants shared by the delayed sound slot table and its checker.
// ----------------------------------------------------------------------------
package psds_pkg;

   localparam logic [1:0] MODE_QUEUE = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [11:0] CODE_MASK    = 12'hfff;
   localparam logic [15:0] LOWEST_START = 16'hffff;

   // One slot of the table. A code of zero means the slot is empty.
   typedef struct packed {
      logic        pending;
      logic [11:0] code;
      logic [15:0] prio;
      logic [15:0] delay;
      logic [15:0] hold;
   } slot_type;

   // Control strobes from the sequencer to the slot memory.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_kill;
      logic clear;
   } ram_ctl_type;

   // Verdict of the slot unit on the entry under examination.
   typedef struct packed {
      logic busy;
      logic match;
      logic better;
      logic play;
      logic kill;
   } alu_flags_type;

endpackage

@@ rtl/psds_ifs.sv @@
// ----------------------------------------------------------------------------
// psds_req_if / psds_rsp_if
// Valid/ready channels carrying request items in and play results out.
// ----------------------------------------------------------------------------
interface psds_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [11:0] sound_id;
   logic [15:0] start_delay;
   logic [15:0] hold_ticks;
   logic [15:0] request_priority;

   modport source (output valid, output mode, output sound_id, output start_delay,
                   output hold_ticks, output request_priority, input ready);
   modport sink   (input valid, input mode, input sound_id, input start_delay,
                   input hold_ticks, input request_priority, output ready);
endinterface

interface psds_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] play_sound;
   logic [4:0]  slot_index;
   logic        last_play;

   modport source (output valid, output play_sound, output slot_index,
                   output last_play, input ready);
   modport sink   (input valid, input play_sound, input slot_index,
                   input last_play, output ready);
endinterface

@@ rtl/psds_slot_ram.sv @@
// ----------------------------------------------------------------------------
// psds_slot_ram
// Slot storage: one write and one registered read per cycle, with a valid bit
// per entry so that reset and clear empty the whole table at once.
// ----------------------------------------------------------------------------
module psds_slot_ram #(
   parameter int DEPTH = 32,
   parameter int IDX_W = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  psds_pkg::ram_ctl_type ctl,
   input  logic [IDX_W-1:0]      wr_addr,
   input  psds_pkg::slot_type    wr_data,
   input  logic [IDX_W-1:0]      rd_addr,
   output psds_pkg::slot_type    rd_data
);

   psds_pkg::slot_type mem [DEPTH];
   logic [DEPTH-1:0]   vld_ff;
   psds_pkg::slot_type rd_data_ff;
   logic               rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end else if (ctl.wr_kill) begin
            vld_ff[wr_addr] <= 1'b0;
         end
         if (ctl.rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // An entry that is not valid reads as an empty slot.
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

@@ rtl/psds_slot_alu.sv @@
// ----------------------------------------------------------------------------
// psds_slot_alu
// Shared slot unit: one decrementer and the priority compares, applied to the
// slot currently read from the table.
// ----------------------------------------------------------------------------
module psds_slot_alu (
   input  logic                    tick,
   input  psds_pkg::slot_type      entry,
   input  psds_pkg::slot_type      req_entry,
   input  logic [15:0]             lowest,
   output psds_pkg::alu_flags_type flags,
   output psds_pkg::slot_type      next_entry,
   output logic [11:0]             play_sound
);

   logic [15:0] operand;
   logic [15:0] dec;
   logic        zero;

   // Pending slots count their delay down, playing slots their hold time.
   assign operand    = entry.pending ? entry.delay : entry.hold;
   assign dec        = operand - 16'd1;
   assign zero       = (operand == 16'd0);
   assign play_sound = entry.code - 12'd1;

   always_comb begin
      flags.busy   = (entry.code != 12'd0);
      flags.match  = flags.busy && (entry.code == req_entry.code);
      flags.better = flags.busy
                     && ((entry.prio < req_entry.prio) || (entry.prio == 16'd0))
                     && (entry.prio < lowest);
      flags.play   = tick && flags.busy && entry.pending && zero;
      flags.kill   = tick && flags.busy && !entry.pending && zero;

      next_entry = entry;
      if (!tick) begin
         next_entry = req_entry;
      end else if (entry.pending) begin
         if (zero) begin
            next_entry.pending = 1'b0;
         end else begin
            next_entry.delay = dec;
         end
      end else begin
         next_entry.hold = dec;
      end
   end

endmodule

@@ rtl/priority_delayed_sound_slots.sv @@
// ----------------------------------------------------------------------------
// priority_delayed_sound_slots
// Table of delayed sound-request slots walked one slot per cycle unless a tick stalls.
// ----------------------------------------------------------------------------
//   channel  | dir | beat contents
//   ---------+-----+-----------------------------------------------------------
//   req_chan | in  | mode, sound_id, start_delay, hold_ticks, request_priority
//   rsp_chan | out | play_sound, slot_index, last_play (one beat per play)
//
// A request or a tick reads one slot of the table per cycle through the single
// read port, though a tick can stall as below; a request ends early at a
// duplicate or an empty slot. A clear empties the table without leaving the idle
// state. Reset empties the table at once through per-slot valid bits. A tick whose
// play finds both the held play and the output register full waits on that slot until the beat is taken.
// ----------------------------------------------------------------------------
module priority_delayed_sound_slots #(
   parameter int SLOT_COUNT = 32
) (
   input logic        clock,
   input logic        reset,
   psds_req_if.sink   req_chan,
   psds_rsp_if.source rsp_chan
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   psds_pkg::slot_type req_ff, req_in;
   logic [IDX_W-1:0]   proc_ff, proc_in;
   logic [15:0]        lowest_ff, lowest_in;
   logic               fb_ok_ff, fb_ok_in;
   logic [IDX_W-1:0]   fb_idx_ff, fb_idx_in;
   logic               held_ok_ff, held_ok_in;
   logic [11:0]        held_sound_ff, held_sound_in;
   logic [4:0]         held_idx_ff, held_idx_in;
   logic               out_valid_ff, out_valid_in;
   logic [11:0]        out_sound_ff, out_sound_in;
   logic [4:0]         out_idx_ff, out_idx_in;
   logic               out_last_ff, out_last_in;

   psds_pkg::ram_ctl_type   ctl;
   logic [IDX_W-1:0]        wr_addr;
   psds_pkg::slot_type      wr_data;
   logic [IDX_W-1:0]        rd_addr;
   psds_pkg::slot_type      rd_data;
   psds_pkg::alu_flags_type flags;
   psds_pkg::slot_type      next_entry;
   logic [11:0]             alu_sound;
   logic [IDX_W+4:0]        proc_wide;
   logic [4:0]              proc_idx5;
   logic [IDX_W-1:0]        proc_next;
   logic                    accept;
   logic                    out_free;
   logic                    at_last;
   logic                    stall;

   psds_slot_ram #(
      .DEPTH (SLOT_COUNT),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   psds_slot_alu u_alu (
      .tick       (mode_ff == psds_pkg::MODE_TICK),
      .entry      (rd_data),
      .req_entry  (req_ff),
      .lowest     (lowest_ff),
      .flags      (flags),
      .next_entry (next_entry),
      .play_sound (alu_sound)
   );

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.play_sound = out_sound_ff;
   assign rsp_chan.slot_index = out_idx_ff;
   assign rsp_chan.last_play  = out_last_ff;

   assign accept    = req_chan.valid && req_chan.ready;
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign proc_wide = {5'd0, proc_ff};
   assign proc_idx5 = proc_wide[4:0];
   assign proc_next = IDX_W'(proc_ff + 1'b1);
   assign at_last   = (proc_ff == LAST_IDX);
   // A second play cannot be held back while the previous one has nowhere to go.
   assign stall     = flags.play && held_ok_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      req_in        = req_ff;
      proc_in       = proc_ff;
      lowest_in     = lowest_ff;
      fb_ok_in      = fb_ok_ff;
      fb_idx_in     = fb_idx_ff;
      held_ok_in    = held_ok_ff;
      held_sound_in = held_sound_ff;
      held_idx_in   = held_idx_ff;
      out_valid_in  = out_valid_ff;
      out_sound_in  = out_sound_ff;
      out_idx_in    = out_idx_ff;
      out_last_in   = out_last_ff;
      ctl           = '0;
      wr_addr       = proc_ff;
      wr_data       = next_entry;
      rd_addr       = proc_next;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (accept) begin
               mode_in        = req_chan.mode;
               req_in.pending = 1'b1;
               req_in.code    = req_chan.sound_id + 12'd1;
               req_in.prio    = req_chan.request_priority;
               req_in.delay   = req_chan.start_delay;
               req_in.hold    = req_chan.hold_ticks;
               lowest_in      = psds_pkg::LOWEST_START;
               fb_ok_in       = 1'b0;
               held_ok_in     = 1'b0;
               proc_in        = '0;
               case (req_chan.mode)
                  psds_pkg::MODE_CLEAR: begin
                     ctl.clear = 1'b1;
                  end
                  psds_pkg::MODE_TICK: begin
                     ctl.rd_en = 1'b1;
                     state_in  = ST_SCAN;
                  end
                  psds_pkg::MODE_QUEUE: begin
                     // Sound id all ones would wrap to the empty code.
                     if (req_chan.sound_id != psds_pkg::CODE_MASK) begin
                        ctl.rd_en = 1'b1;
                        state_in  = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (mode_ff == psds_pkg::MODE_TICK) begin
               if (!stall) begin
                  ctl.wr_en   = flags.busy && !flags.kill;
                  ctl.wr_kill = flags.kill;
                  if (flags.play) begin
                     if (held_ok_ff) begin
                        out_valid_in = 1'b1;
                        out_sound_in = held_sound_ff;
                        out_idx_in   = held_idx_ff;
                        out_last_in  = 1'b0;
                     end
                     held_ok_in    = 1'b1;
                     held_sound_in = alu_sound;
                     held_idx_in   = proc_idx5;
                  end
                  if (at_last) begin
                     state_in = ST_FLUSH;
                  end else begin
                     ctl.rd_en = 1'b1;
                     proc_in   = proc_next;
                  end
               end
            end else if (flags.match) begin
               state_in = ST_IDLE;
            end else if (!flags.busy) begin
               ctl.wr_en = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               if (flags.better) begin
                  lowest_in = rd_data.prio;
                  fb_ok_in  = 1'b1;
                  fb_idx_in = proc_ff;
               end
               if (at_last) begin
                  ctl.wr_en = flags.better || fb_ok_ff;
                  wr_addr   = flags.better ? proc_ff : fb_idx_ff;
                  state_in  = ST_IDLE;
               end else begin
                  ctl.rd_en = 1'b1;
                  proc_in   = proc_next;
               end
            end
         end

         ST_FLUSH: begin
            if (!held_ok_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_sound_in = held_sound_ff;
               out_idx_in   = held_idx_ff;
               out_last_in  = 1'b1;
               held_ok_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fb_ok_ff     <= 1'b0;
         held_ok_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fb_ok_ff     <= fb_ok_in;
         held_ok_ff   <= held_ok_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      req_ff        <= req_in;
      proc_ff       <= proc_in;
      lowest_ff     <= lowest_in;
      fb_idx_ff     <= fb_idx_in;
      held_sound_ff <= held_sound_in;
      held_idx_ff   <= held_idx_in;
      out_sound_ff  <= out_sound_in;
      out_idx_ff    <= out_idx_in;
      out_last_ff   <= out_last_in;
   end

endmodule

@@ rtl/psds_chk.sv @@
// ----------------------------------------------------------------------------
// psds_chk
// Port-level checks on the delayed sound slot table, bound to the top level.
// ----------------------------------------------------------------------------
module psds_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_play_sound,
   input logic [4:0]  rsp_slot_index,
   input logic        rsp_last_play
);

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_play_sound)
         && $stable(rsp_slot_index) && $stable(rsp_last_play))
      else $error("result beat changed while stalled");

   // A clear completes in the cycle it is taken.
   a_clear_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == psds_pkg::MODE_CLEAR) |=> req_ready)
      else $error("clear did not complete at once");

   // A tick always walks the table.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == psds_pkg::MODE_TICK) |=> !req_ready)
      else $error("tick did not start a walk");

   // New results only come out of a walk in progress.
   a_rsp_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while idle");

endmodule

bind priority_delayed_sound_slots psds_chk u_psds_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_mode       (req_chan.mode),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_play_sound (rsp_chan.play_sound),
   .rsp_slot_index (rsp_chan.slot_index),
   .rsp_last_play  (rsp_chan.last_play)
);
